// ----- rtl/core/tsdfl_pkg.sv -----
// shared types and constants for the two-sided deferred free list
`timescale 1ns / 1ps

package tsdfl_pkg;

  localparam int IDX_W       = 10;
  localparam int LINK_W      = IDX_W + 1;
  localparam int CMDQ_DEPTH  = 2;
  localparam int OUTQ_DEPTH  = 4;

  localparam logic CMD_FREE    = 1'b0;
  localparam logic CMD_RECLAIM = 1'b1;

  // classified command as it sits in the front queue
  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] node_index;
    logic             in_range;
  } cmd_t;

  // one result as it sits in the output queue
  typedef struct packed {
    logic [IDX_W-1:0] freed_index;
    logic             freed_valid;
    logic             doorbell;
    logic             more_left;
    logic             pending;
    logic             last;
  } res_t;

endpackage

// ----- rtl/core/tsdfl_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tsdfl_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/tsdfl_front.sv -----
// front end: takes commands, checks the node range, queues them for the back end
`timescale 1ns / 1ps

module tsdfl_front import tsdfl_pkg::*; #(
  parameter int NODE_COUNT = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic             in_command,
  input  logic [IDX_W-1:0] in_node_index,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_pop
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             q_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;
  cmd_t             entry;

  assign full      = (count_r == CNT_W'(CMDQ_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    entry.command    = in_command;
    entry.node_index = in_node_index;
    entry.in_range   = (32'(in_node_index) < NODE_COUNT);
  end

  always_comb begin
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// ----- rtl/core/tsdfl_back.sv -----
// back end: side state, link memory and the reclaim walk sequencer
`timescale 1ns / 1ps

module tsdfl_back import tsdfl_pkg::*; #(
  parameter int NODE_COUNT = 1024,
  parameter int BATCH_CAP  = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic res_valid,
  output res_t res,
  input  logic res_ready
);

  localparam int LINK_DEPTH = (NODE_COUNT < (1 << IDX_W)) ? NODE_COUNT : (1 << IDX_W);
  localparam int AW         = $clog2(LINK_DEPTH);
  localparam int CNT_W      = $clog2(BATCH_CAP + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(BATCH_CAP);
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CNT  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic             active_r, active_nxt;
  logic [IDX_W-1:0] head_r [2];
  logic [IDX_W-1:0] head_nxt [2];
  logic [1:0]       nonempty_r, nonempty_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             more_r, more_nxt;
  logic             pend_r, pend_nxt;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [LINK_W-1:0] wdata;
  logic [LINK_W-1:0] rdata;
  logic [IDX_W-1:0]  link_idx;
  logic              link_ok;
  logic              side;
  logic              last;

  tsdfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cur_nxt[AW-1:0]),
    .rdata (rdata)
  );

  // rdata always holds the link of cur_r while walking
  assign link_idx = rdata[IDX_W-1:0];
  assign link_ok  = rdata[IDX_W] && (32'(link_idx) < NODE_COUNT);
  assign side     = !active_r;
  assign last     = (cnt_r == ONE);

  always_comb begin
    state_nxt    = state_r;
    active_nxt   = active_r;
    head_nxt     = head_r;
    nonempty_nxt = nonempty_r;
    cur_nxt      = cur_r;
    start_nxt    = start_r;
    cnt_nxt      = cnt_r;
    more_nxt     = more_r;
    pend_nxt     = pend_r;
    cmd_pop      = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    we           = 1'b0;
    waddr        = cmd.node_index[AW-1:0];
    wdata        = '0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.command == CMD_FREE) begin
            res_valid    = 1'b1;
            res.last     = 1'b1;
            res.doorbell = cmd.in_range && !nonempty_r[active_r];
            res.pending  = cmd.in_range || (|nonempty_r);
            if (res_ready) begin
              cmd_pop = 1'b1;
              if (cmd.in_range) begin
                we = 1'b1;
                wdata = nonempty_r[active_r] ? {1'b1, head_r[active_r]} : '0;
                head_nxt[active_r]     = cmd.node_index;
                nonempty_nxt[active_r] = 1'b1;
              end
            end
          end else if (nonempty_r[side]) begin
            cmd_pop   = 1'b1;
            cur_nxt   = head_r[side];
            start_nxt = head_r[side];
            cnt_nxt   = ONE;
            state_nxt = S_CNT;
          end else begin
            res_valid   = 1'b1;
            res.last    = 1'b1;
            res.pending = nonempty_r[active_r];
            if (res_ready) begin
              cmd_pop    = 1'b1;
              active_nxt = side;
            end
          end
        end
      end

      S_CNT: begin
        if (cnt_r == CAP || !link_ok) begin
          // walk finished: commit the side state, then replay from the start
          head_nxt[side]     = link_idx;
          nonempty_nxt[side] = link_ok;
          more_nxt           = link_ok;
          pend_nxt           = link_ok || nonempty_r[active_r];
          if (!link_ok) begin
            active_nxt = side;
          end
          cur_nxt   = start_r;
          state_nxt = S_EMIT;
        end else begin
          cur_nxt = link_idx;
          cnt_nxt = CNT_W'(cnt_r + 1'b1);
        end
      end

      S_EMIT: begin
        res_valid       = 1'b1;
        res.freed_index = cur_r;
        res.freed_valid = 1'b1;
        res.more_left   = last && more_r;
        res.pending     = pend_r;
        res.last        = last;
        if (res_ready) begin
          if (last) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt = link_idx;
            cnt_nxt = CNT_W'(cnt_r - 1'b1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      active_r   <= 1'b0;
      head_r[0]  <= '0;
      head_r[1]  <= '0;
      nonempty_r <= '0;
      cnt_r      <= '0;
      more_r     <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      head_r     <= head_nxt;
      nonempty_r <= nonempty_nxt;
      cnt_r      <= cnt_nxt;
      more_r     <= more_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    start_r <= start_nxt;
  end

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cnt_r != '0))
    else $error("replay walk entered with zero count");

  a_bell_no_node: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.doorbell) |-> (!res.freed_valid && state_r == S_IDLE))
    else $error("doorbell raised on a reclaim result");

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.more_left) |-> (res.pending && res.last))
    else $error("more_left without pending or off the last result");

endmodule

// ----- rtl/core/tsdfl_outq.sv -----
// output queue: holds results until the consumer pops them
`timescale 1ns / 1ps

module tsdfl_outq import tsdfl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic res_valid,
  input  res_t res,
  output logic res_ready,
  output logic empty,
  input  logic pop,
  output res_t head
);

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  res_t             q_r [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign res_ready = (count_r != CNT_W'(OUTQ_DEPTH));
  assign empty     = (count_r == '0);
  assign head      = q_r[rd_ptr_r];
  assign do_push   = res_valid && res_ready;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule

// ----- rtl/core/two_sided_deferred_free_list_unit.sv -----
// top level of the two-sided deferred free list
// a free or empty reclaim reaches the out ports through the front and output queue registers
// free: link write plus head update together; one free per cycle while the output queue has room
// reclaim of n nodes: an issue step, S_CNT counting the chain, S_EMIT handing out results,
//   one link read per cycle; S_EMIT waits while the output queue is full
// reset: synchronous active-low clears both queues, side heads, flags and the sequencer; the link
//   ram is not cleared, entries are only read after being written
`timescale 1ns / 1ps

module two_sided_deferred_free_list_unit import tsdfl_pkg::*; #(
  parameter int NODE_COUNT = 1024,
  parameter int BATCH_CAP  = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  // command side
  input  logic             push,
  output logic             full,
  input  logic             in_command,
  input  logic [IDX_W-1:0] in_node_index,
  // result side
  output logic             empty,
  input  logic             pop,
  output logic [IDX_W-1:0] out_freed_index,
  output logic             out_freed_valid,
  output logic             out_doorbell,
  output logic             out_more_left,
  output logic             out_pending,
  output logic             out_last
);

  // front to back command queue
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // back to output queue
  logic res_valid;
  res_t res;
  logic res_ready;
  res_t head;

  // front end classifies each transfer (range check on the node) and buffers it
  tsdfl_front #(
    .NODE_COUNT (NODE_COUNT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_command    (in_command),
    .in_node_index (in_node_index),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // back end owns the side state and walks the link chains
  tsdfl_back #(
    .NODE_COUNT (NODE_COUNT),
    .BATCH_CAP  (BATCH_CAP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // results wait here so the back end keeps working while the consumer stalls, until the queue is full
  tsdfl_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  // unpack the oldest waiting result onto the ports
  assign out_freed_index = head.freed_index;
  assign out_freed_valid = head.freed_valid;
  assign out_doorbell    = head.doorbell;
  assign out_more_left   = head.more_left;
  assign out_pending     = head.pending;
  assign out_last        = head.last;

endmodule
